@@ hdl/hclf_pkg.sv @@
// Shared package for the HTTP Content-Length framer.
// Holds the key tag, status/phase/line codes and the byte class record.
// No dependencies.
package hclf_pkg;

    localparam int BUFFER_BYTES_DEF = 8192;
    localparam int TAG_LEN          = 15;
    localparam int OUT_W            = 13;
    localparam int OUT_MAX          = 8191;
    localparam int QDEPTH           = 2;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    // "Content-Length:"
    localparam logic [7:0] LEN_TAG [TAG_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    localparam logic [2:0] ST_HEADERS = 3'd0;
    localparam logic [2:0] ST_BODY    = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [1:0] PH_HEADERS = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_ENDED   = 2'd2;

    localparam logic [1:0] LM_KEY   = 2'd0;
    localparam logic [1:0] LM_VALUE = 2'd1;
    localparam logic [1:0] LM_OTHER = 2'd2;

    typedef struct packed {
        logic               new_req;
        logic [TAG_LEN-1:0] tag_hit;   // bit k: byte equals tag character k
        logic               is_cr;
        logic               is_lf;
        logic               is_blank;
        logic               is_digit;
        logic [3:0]         digit;
    } class_t;

endpackage

@@ hdl/http_content_length_framer.sv @@
// Top level of the HTTP Content-Length framer.
// Instantiates hclf_front, hclf_queue and hclf_back; uses hclf_pkg.
//
// One request byte goes in per cycle and exactly one result comes out for
// each byte, in order. Sustained rate is one byte per clock while the result
// side keeps up; a byte's result is presented on the master side after the
// byte passes the two-entry class queue and the parser registers the result.
// The parser state for each byte, including the 64-bit length accumulator,
// is computed combinationally and registered when the byte is popped, so
// there is no per-byte stall. s_tready drops only when the queue is full
// because the result side is held off. No clearing pass is needed after
// reset.
module http_content_length_framer
    import hclf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] new_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [2:0] status, [15:3] body_length,
                                   // [28:16] byte_total, [31:29] zero
);

    class_t           f_cls;
    class_t           q_cls;
    logic             q_valid, q_ready;
    logic [2:0]       status;
    logic [OUT_W-1:0] body_length, byte_total;

    hclf_front u_front (
        .data_byte   (s_tdata),
        .new_request (s_tuser),
        .cls         (f_cls)
    );

    hclf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (f_cls),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cls)
    );

    hclf_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_cls),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .status      (status),
        .body_length (body_length),
        .byte_total  (byte_total)
    );

    assign m_tdata = {3'b000, byte_total, body_length, status};

endmodule

@@ hdl/hclf_front.sv @@
// Front end of the framer: classifies each received byte.
// Depends on hclf_pkg.
module hclf_front
    import hclf_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       new_request,
    output class_t     cls
);

    logic [TAG_LEN-1:0] hit;
    logic [3:0]         off;

    always_comb begin
        for (int k = 0; k < TAG_LEN; k++) begin
            hit[k] = (data_byte == LEN_TAG[k]);
        end
    end

    assign off = data_byte[3:0] - CH_0[3:0];

    assign cls.new_req  = new_request;
    assign cls.tag_hit  = hit;
    assign cls.is_cr    = (data_byte == CH_CR);
    assign cls.is_lf    = (data_byte == CH_LF);
    assign cls.is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB);
    assign cls.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
    assign cls.digit    = off;

endmodule

@@ hdl/hclf_queue.sv @@
// Short queue of classified bytes between front and back end.
// Depends on hclf_pkg.
module hclf_queue
    import hclf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  class_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output class_t rd_data
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    class_t           slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   fill_reg, fill_next;
    logic             push, pop;

    assign wr_ready = (fill_reg != QCW'(QDEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/hclf_back.sv @@
// Back end of the framer: line parser, length capture, completion and limit
// checks, and the result register. Depends on hclf_pkg.
module hclf_back
    import hclf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  class_t           q_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       status,
    output logic [OUT_W-1:0] body_length,
    output logic [OUT_W-1:0] byte_total
);

    localparam int CW = $clog2(BUFFER_BYTES);
    localparam int XW = (CW > OUT_W) ? CW : OUT_W;
    localparam logic [CW-1:0] BMAX = CW'(BUFFER_BYTES - 1);

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    pos_reg, pos_next;
    logic [1:0]    mode_reg, mode_next;
    logic          hcr_reg, hcr_next;
    logic [63:0]   dacc_reg, dacc_next;
    logic          dp_reg, dp_next;
    logic          la_reg, la_next;
    logic [63:0]   alen_reg, alen_next;
    logic [CW-1:0] tgt_reg, tgt_next;

    logic             m_valid_reg;
    logic [2:0]       status_reg, status_next;
    logic [OUT_W-1:0] blen_reg, btot_reg;

    logic          pop;
    logic [67:0]   prod;
    logic [CW-1:0] room;
    logic          decided;
    logic [XW-1:0] cnt_x;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        // start of request wipes all parse state before this byte
        phase_next = q_data.new_req ? PH_HEADERS : phase_reg;
        cnt_next   = q_data.new_req ? '0 : cnt_reg;
        pos_next   = q_data.new_req ? '0 : pos_reg;
        mode_next  = q_data.new_req ? LM_KEY : mode_reg;
        hcr_next   = q_data.new_req ? 1'b0 : hcr_reg;
        dacc_next  = q_data.new_req ? '0 : dacc_reg;
        dp_next    = q_data.new_req ? 1'b0 : dp_reg;
        la_next    = q_data.new_req ? 1'b0 : la_reg;
        alen_next  = q_data.new_req ? '0 : alen_reg;
        tgt_next   = q_data.new_req ? '0 : tgt_reg;
        status_next = ST_IGNORED;
        decided     = 1'b0;
        room        = '0;
        prod = ({4'b0, dacc_next} << 3) + ({4'b0, dacc_next} << 1) + {64'b0, q_data.digit};

        if (phase_next != PH_ENDED) begin
            cnt_next = cnt_next + 1'b1;
            if (phase_next == PH_HEADERS) begin
                if (hcr_next && q_data.is_lf) begin
                    hcr_next = 1'b0;
                    if (mode_next == LM_KEY && pos_next == '0) begin
                        room = BMAX - cnt_next;
                        if ((|alen_next[63:CW]) || (alen_next[CW-1:0] > room)) begin
                            phase_next  = PH_ENDED;
                            status_next = ST_REJECT;
                            decided     = 1'b1;
                        end else begin
                            tgt_next   = cnt_next + alen_next[CW-1:0];
                            phase_next = PH_BODY;
                        end
                    end else begin
                        if (mode_next == LM_VALUE && dp_next && !la_next) begin
                            alen_next = dacc_next;
                            la_next   = 1'b1;
                        end
                        pos_next  = '0;
                        mode_next = LM_KEY;
                        dacc_next = '0;
                        dp_next   = 1'b0;
                    end
                end else if (hcr_next) begin
                    // held CR turns into line content, which spoils any key
                    mode_next = LM_OTHER;
                    hcr_next  = q_data.is_cr;
                end else if (q_data.is_cr) begin
                    hcr_next = 1'b1;
                end else begin
                    unique case (mode_next)
                        LM_KEY: begin
                            if (pos_next < 4'(TAG_LEN) && q_data.tag_hit[pos_next]) begin
                                pos_next = pos_next + 1'b1;
                                if (pos_next == 4'(TAG_LEN)) begin
                                    mode_next = LM_VALUE;
                                end
                            end else begin
                                mode_next = LM_OTHER;
                            end
                        end
                        LM_VALUE: begin
                            if (q_data.is_blank && !dp_next) begin
                                mode_next = LM_VALUE;
                            end else if (q_data.is_digit) begin
                                if (|prod[67:64]) begin
                                    mode_next = LM_OTHER;
                                end else begin
                                    dacc_next = prod[63:0];
                                    dp_next   = 1'b1;
                                end
                            end else begin
                                mode_next = LM_OTHER;
                            end
                        end
                        default: mode_next = LM_OTHER;
                    endcase
                end
            end

            if (!decided) begin
                if (phase_next == PH_BODY && cnt_next >= tgt_next) begin
                    phase_next  = PH_ENDED;
                    status_next = ST_DONE;
                end else if (cnt_next >= BMAX) begin
                    phase_next  = PH_ENDED;
                    status_next = ST_REJECT;
                end else if (phase_next == PH_BODY) begin
                    status_next = ST_BODY;
                end else begin
                    status_next = ST_HEADERS;
                end
            end
        end
    end

    assign cnt_x = XW'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADERS;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            mode_reg    <= LM_KEY;
            hcr_reg     <= 1'b0;
            dacc_reg    <= '0;
            dp_reg      <= 1'b0;
            la_reg      <= 1'b0;
            alen_reg    <= '0;
            tgt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg   <= phase_next;
                cnt_reg     <= cnt_next;
                pos_reg     <= pos_next;
                mode_reg    <= mode_next;
                hcr_reg     <= hcr_next;
                dacc_reg    <= dacc_next;
                dp_reg      <= dp_next;
                la_reg      <= la_next;
                alen_reg    <= alen_next;
                tgt_reg     <= tgt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            blen_reg   <= (|alen_next[63:OUT_W]) ? OUT_W'(OUT_MAX) : alen_next[OUT_W-1:0];
            btot_reg   <= (cnt_x > XW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : cnt_x[OUT_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign status      = status_reg;
    assign body_length = blen_reg;
    assign byte_total  = btot_reg;

    a_body_before_target: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> cnt_reg < tgt_reg)
        else $error("body phase past its target count");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_ENDED |-> cnt_reg < BMAX)
        else $error("open request reached the byte limit");

    a_len_only_when_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        !la_reg |-> alen_reg == '0)
        else $error("length held without a length line");

    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (status_next == ST_DONE || status_next == ST_REJECT)
        |=> phase_reg == PH_ENDED && m_valid_reg)
        else $error("final status without ended phase");

endmodule

@@ test/tb.sv @@
// Testbench for http_content_length_framer: streams request bytes into the
// framer and checks every result against a byte-level model of the parser.
// Depends on hclf_pkg and the framer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hclf_pkg::*;

    localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
    localparam int LIMIT        = BUF_BYTES - 1;
    localparam int RANDOM_BYTES = 120;

    typedef logic [7:0] octet_q_t[$];

    typedef struct packed {
        logic [2:0]       status;
        logic [OUT_W-1:0] body_len;
        logic [OUT_W-1:0] total;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // [0] new_request
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [2:0] status, [15:3] body_length, [28:16] byte_total

    frame_result_t expected_results[$];
    int            mismatches;
    int            framed_bytes;     // request bytes that were not ignored after an end
    bit            tx_calm;
    bit            rx_calm;
    int            rx_hold_cycles;

    // parser mirror
    logic [1:0]  fr_phase;
    int unsigned fr_count;
    int unsigned fr_line_pos;
    logic [1:0]  fr_line_mode;
    bit          fr_cr_held;
    logic [63:0] fr_digits;
    bit          fr_have_digit;
    bit          fr_len_taken;
    logic [63:0] fr_length;
    int unsigned fr_target;

    http_content_length_framer #(.BUFFER_BYTES(BUF_BYTES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void clear_line();
        fr_line_pos   = 0;
        fr_line_mode  = LM_KEY;
        fr_digits     = '0;
        fr_have_digit = 1'b0;
    endfunction

    function automatic void clear_request();
        fr_phase     = PH_HEADERS;
        fr_count     = 0;
        fr_cr_held   = 1'b0;
        fr_len_taken = 1'b0;
        fr_length    = '0;
        fr_target    = 0;
        clear_line();
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [63:0] d;
        if (fr_line_mode == LM_KEY) begin
            if (fr_line_pos < TAG_LEN && c == LEN_TAG[fr_line_pos]) begin
                fr_line_pos++;
                if (fr_line_pos == TAG_LEN)
                    fr_line_mode = LM_VALUE;
            end else begin
                fr_line_mode = LM_OTHER;
            end
        end else if (fr_line_mode == LM_VALUE) begin
            if ((c == CH_SP || c == CH_TAB) && !fr_have_digit) begin
                // leading blank, skipped
            end else if (c >= CH_0 && c <= CH_9) begin
                d = 64'(c - CH_0);
                if (fr_digits > ({64{1'b1}} - d) / 10) begin
                    fr_line_mode = LM_OTHER;
                end else begin
                    fr_digits     = fr_digits * 10 + d;
                    fr_have_digit = 1'b1;
                end
            end else begin
                fr_line_mode = LM_OTHER;
            end
        end else begin
            fr_line_mode = LM_OTHER;
        end
    endfunction

    // Advance the mirror by one request byte and queue the result it causes.
    function automatic void frame_byte(input logic [7:0] b, input bit fresh);
        frame_result_t res;
        int unsigned   cnt;
        bit            decided;
        logic [63:0]   room;
        if (fresh)
            clear_request();
        if (fr_phase == PH_ENDED) begin
            res.status = ST_IGNORED;
        end else begin
            cnt      = fr_count + 1;
            fr_count = cnt;
            decided  = 1'b0;
            if (fr_phase == PH_HEADERS) begin
                if (fr_cr_held && b == CH_LF) begin
                    fr_cr_held = 1'b0;
                    if (fr_line_mode == LM_KEY && fr_line_pos == 0) begin
                        // empty line: body must still fit in the buffer
                        room = (cnt <= LIMIT) ? 64'(LIMIT - cnt) : 64'd0;
                        if (fr_length > room) begin
                            fr_phase   = PH_ENDED;
                            res.status = ST_REJECT;
                            decided    = 1'b1;
                        end else begin
                            fr_target = cnt + fr_length[31:0];
                            fr_phase  = PH_BODY;
                        end
                    end else begin
                        if (fr_line_mode == LM_VALUE && fr_have_digit && !fr_len_taken) begin
                            fr_length    = fr_digits;
                            fr_len_taken = 1'b1;
                        end
                        clear_line();
                    end
                end else begin
                    // a held CR without LF is plain line content
                    if (fr_cr_held) begin
                        take_char(CH_CR);
                        fr_cr_held = 1'b0;
                    end
                    if (b == CH_CR)
                        fr_cr_held = 1'b1;
                    else
                        take_char(b);
                end
            end
            if (!decided) begin
                if (fr_phase == PH_BODY && cnt >= fr_target) begin
                    fr_phase   = PH_ENDED;
                    res.status = ST_DONE;
                end else if (cnt >= LIMIT) begin
                    fr_phase   = PH_ENDED;
                    res.status = ST_REJECT;
                end else begin
                    res.status = (fr_phase == PH_BODY) ? ST_BODY : ST_HEADERS;
                end
            end
            framed_bytes++;
        end
        res.body_len = (fr_length > OUT_MAX) ? OUT_W'(OUT_MAX) : fr_length[OUT_W-1:0];
        res.total    = (fr_count > OUT_MAX) ? OUT_W'(OUT_MAX) : fr_count[OUT_W-1:0];
        expected_results.push_back(res);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result %h arrived with no request pending", m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, m_tdata[2:0]);
                check_field("body_length", want.body_len, m_tdata[15:3]);
                check_field("byte_total", want.total, m_tdata[28:16]);
                check_field("pad", 0, m_tdata[31:29]);
            end
        end
    end

    function automatic int gap_cycles(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls plus a forced hold-off when a test asks for one.
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = gap_cycles(rx_calm);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input bit fresh);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= fresh;
        do @(posedge aclk); while (!s_tready);
        frame_byte(value, fresh);
        gap = gap_cycles(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_request(input octet_q_t q);
        foreach (q[i])
            send_byte(q[i], i == 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    function automatic void add_text(ref octet_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic void add_eol(ref octet_q_t q);
        q.push_back(CH_CR);
        q.push_back(CH_LF);
    endfunction

    function automatic void add_line(ref octet_q_t q, input string s);
        add_text(q, s);
        add_eol(q);
    endfunction

    function automatic void add_random(ref octet_q_t q, input int n);
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_zero_length();
        octet_q_t req;
        add_eol(req);
        add_random(req, 2);
        send_request(req);
        req.delete();
        add_line(req, "Content-Length: 0");
        add_eol(req);
        add_random(req, 1);
        send_request(req);
    endtask

    task automatic test_length_line();
        octet_q_t req;
        add_line(req, "Host: x");
        add_line(req, "Content-Length:\t 12");
        add_line(req, "Content-Length: 3");    // later length line has no effect
        add_eol(req);
        add_random(req, 14);
        send_request(req);
    endtask

    task automatic test_malformed_lines();
        octet_q_t req;
        add_line(req, "Content-Length: 4 ");
        add_line(req, "Content-Length:");
        add_line(req, "content-length: 4");
        add_line(req, "Content-Length: 4x");
        add_line(req, " Content-Length: 4");
        add_line(req, "Content-Length: 18446744073709551616");
        add_text(req, "Content-Length: 5");
        req.push_back(CH_CR);
        add_line(req, "5");
        req.push_back(CH_CR);                  // a lone CR keeps the line non-empty
        add_eol(req);
        add_eol(req);
        add_random(req, 1);
        send_request(req);
    endtask

    task automatic test_max_value();
        octet_q_t req;
        add_line(req, "Content-Length: 18446744073709551615");
        add_eol(req);
        add_random(req, 2);
        send_request(req);
    endtask

    task automatic test_restart();
        octet_q_t req;
        add_text(req, "Content-Le");
        send_request(req);
        req.delete();
        add_line(req, "Content-Length: 2");
        add_eol(req);
        add_random(req, 1);                    // cut off inside the body
        send_request(req);
        req.delete();
        add_line(req, "Content-Length: 1");
        add_eol(req);
        add_random(req, 1);
        send_request(req);
        req.delete();
        add_eol(req);
        send_request(req);
    endtask

    task automatic test_long_stall();
        octet_q_t req;
        add_line(req, "Content-Length: 40");
        add_eol(req);
        add_random(req, 42);
        tx_calm = 1'b1;
        rx_hold_cycles = 300;
        send_request(req);
        drain();
        tx_calm = 1'b0;
    endtask

    task automatic test_size_limit();
        octet_q_t req;
        int       body;
        // header is 24 bytes with a four-digit length: largest body that fits
        body = LIMIT - 24;
        add_line(req, $sformatf("Content-Length: %0d", body));
        add_eol(req);
        add_random(req, 3);                    // enters the body, then cut off
        send_request(req);
        req.delete();
        add_line(req, $sformatf("Content-Length: %0d", body + 1));
        add_eol(req);
        add_random(req, 2);
        send_request(req);
    endtask

    task automatic random_request();
        octet_q_t req;
        int       lines;
        int       value;
        int       start;
        int       keep;
        int       body;
        bit       have_len;
        lines    = $urandom_range(0, 3);
        body     = 0;
        have_len = 1'b0;
        for (int i = 0; i < lines; i++) begin
            case ($urandom_range(0, 2))
                0: begin
                    add_random(req, $urandom_range(1, 10));
                    add_eol(req);
                end
                1: begin
                    value = ($urandom_range(0, 9) == 0) ? $urandom_range(7000, 9000)
                                                        : $urandom_range(0, 40);
                    add_text(req, "Content-Length:");
                    repeat ($urandom_range(0, 2))
                        req.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
                    if ($urandom_range(0, 4) == 0)
                        req.push_back(CH_0);
                    add_line(req, $sformatf("%0d", value));
                    if (!have_len) begin
                        have_len = 1'b1;
                        body     = value;
                    end
                end
                default: begin
                    start = req.size();
                    add_text(req, $sformatf("Content-Length: %0d", $urandom_range(0, 40)));
                    case ($urandom_range(0, 4))
                        0: req.push_back(CH_SP);
                        1: req.push_back(CH_CR);
                        2: add_text(req, "99999999999999999999");
                        3: begin
                            keep = start + $urandom_range(0, TAG_LEN - 1);
                            req[keep] = req[keep] ^ 8'($urandom_range(1, 255));
                        end
                        default: add_random(req, 1);
                    endcase
                    add_eol(req);
                end
            endcase
        end
        add_eol(req);
        if (have_len && body <= 200)
            add_random(req, body);
        add_random(req, $urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, req.size());
            while (req.size() > keep)
                void'(req.pop_back());
        end
        send_request(req);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    endtask

    task automatic test_random();
        int start;
        start = framed_bytes;
        while (framed_bytes - start < RANDOM_BYTES) begin
            tx_calm = ($urandom_range(0, 5) == 0);
            rx_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                noise_burst();
            else
                random_request();
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        clear_request();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_length();
        test_length_line();
        test_malformed_lines();
        test_max_value();
        test_restart();
        test_long_stall();
        test_size_limit();
        test_random();

        drain();
        repeat (6) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/hclf_pkg.sv
hdl/hclf_front.sv
hdl/hclf_queue.sv
hdl/hclf_back.sv
hdl/http_content_length_framer.sv
test/tb.sv
